// File: sv/rycc_pkg.sv
// Shared types, sizes and fixed-point constants of the RGB to YCbCr 4:2:0 converter.
// No dependencies; used by every other file of the block.
package rycc_pkg;

    localparam int MAX_LINE_WIDTH   = 4096;
    localparam int MAX_FRAME_HEIGHT = 4096;
    localparam int PAIR_DEPTH       = MAX_LINE_WIDTH / 2;
    localparam int PAIR_IDX_W       = $clog2(PAIR_DEPTH);
    localparam int CNT_W            = 12;
    localparam int CFG_W            = 13;
    localparam int PROD_W           = 27;

    typedef enum logic {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] blue_chroma_avg;
        logic [7:0] red_chroma_avg;
    } t_quad;

    // Raster position of an item as it travels down the pipe
    typedef struct packed {
        logic                  col_odd;
        logic                  row_odd;
        logic [PAIR_IDX_W-1:0] idx;
    } t_pos;

    typedef struct packed {
        logic [7:0]  luma;
        logic [21:0] cb14;
        logic [21:0] cr14;
    } t_pix_val;

    // One line store entry: top-row pair
    typedef struct packed {
        logic [7:0]  luma_left;
        logic [7:0]  luma_right;
        logic [22:0] cb_sum;
        logic [22:0] cr_sum;
    } t_pair;

    // Coefficients scaled by 2^16, order R, G, B
    localparam logic signed [17:0] K_Y  [3] = '{18'sd16829, 18'sd33039, 18'sd6416};
    localparam logic signed [17:0] K_CB [3] = '{-18'sd9714, -18'sd19070, 18'sd28784};
    localparam logic signed [17:0] K_CR [3] = '{18'sd28784, -18'sd24103, -18'sd4681};

    localparam logic signed [PROD_W-1:0] Y_OFFSET = PROD_W'((16 << 16) + (1 << 15));
    localparam logic signed [PROD_W-1:0] C_OFFSET = PROD_W'((128 << 16) + 2);
    localparam logic [24:0]              AVG_ROUND = 25'(1 << 15);

endpackage

// File: sv/rycc_if.sv
// Valid/ready channel interfaces for pixel items in and quad items out.
// Depends on rycc_pkg for the payload types.
interface rycc_pix_if;
    logic             valid;
    logic             ready;
    rycc_pkg::t_pixel payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rycc_quad_if;
    logic            valid;
    logic            ready;
    rycc_pkg::t_quad payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/rycc_color_calc.sv
// Three-stage colour matrix: input capture, products, sums to Y / Cb14 / Cr14.
// Depends on rycc_pkg; advances on the shared pipeline enable.
module rycc_color_calc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  rycc_pkg::t_pixel    i_pix,
    input  rycc_pkg::t_pos      i_pos,
    output logic                o_b_valid,
    output rycc_pkg::t_pos      o_b_pos,
    output logic                o_c_valid,
    output rycc_pkg::t_pos      o_c_pos,
    output rycc_pkg::t_pix_val  o_c_val
);
    import rycc_pkg::*;

    logic                     r_a_valid, r_b_valid, r_c_valid;
    t_pixel                   r_a_pix;
    t_pos                     r_a_pos, r_b_pos, r_c_pos;
    logic signed [PROD_W-1:0] r_py [3];
    logic signed [PROD_W-1:0] r_pb [3];
    logic signed [PROD_W-1:0] r_pr [3];
    logic signed [PROD_W-1:0] n_py [3];
    logic signed [PROD_W-1:0] n_pb [3];
    logic signed [PROD_W-1:0] n_pr [3];
    logic signed [8:0]        chan [3];
    logic signed [PROD_W-1:0] y_acc, cb_acc, cr_acc;
    t_pix_val                 r_c_val, n_c_val;

    always_comb begin
        chan[0] = $signed({1'b0, r_a_pix.red});
        chan[1] = $signed({1'b0, r_a_pix.green});
        chan[2] = $signed({1'b0, r_a_pix.blue});
        for (int i = 0; i < 3; i++) begin
            n_py[i] = K_Y[i]  * chan[i];
            n_pb[i] = K_CB[i] * chan[i];
            n_pr[i] = K_CR[i] * chan[i];
        end
    end

    always_comb begin
        y_acc  = r_py[0] + r_py[1] + r_py[2] + Y_OFFSET;
        cb_acc = r_pb[0] + r_pb[1] + r_pb[2] + C_OFFSET;
        cr_acc = r_pr[0] + r_pr[1] + r_pr[2] + C_OFFSET;
        n_c_val.luma = y_acc[23:16];
        n_c_val.cb14 = cb_acc[23:2];
        n_c_val.cr14 = cr_acc[23:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pix <= i_pix;
            r_a_pos <= i_pos;
            r_b_pos <= r_a_pos;
            r_c_pos <= r_b_pos;
            r_py    <= n_py;
            r_pb    <= n_pb;
            r_pr    <= n_pr;
            r_c_val <= n_c_val;
        end
    end

    assign o_b_valid = r_b_valid;
    assign o_b_pos   = r_b_pos;
    assign o_c_valid = r_c_valid;
    assign o_c_pos   = r_c_pos;
    assign o_c_val   = r_c_val;

    // stage valids only move on the enable
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> r_c_valid == $past(r_c_valid) && r_b_valid == $past(r_b_valid))
        else $error("pipeline valid changed while stalled");

endmodule

// File: sv/rycc_pair_store.sv
// Line store of top-row pairs, left-pixel hold and quad output register.
// Depends on rycc_pkg and rycc_quad_if; memory is 2048 x 62, one read and one write port.
module rycc_pair_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_b_valid,
    input  rycc_pkg::t_pos      i_b_pos,
    input  logic                i_c_valid,
    input  rycc_pkg::t_pos      i_c_pos,
    input  rycc_pkg::t_pix_val  i_c_val,
    rycc_quad_if.source         o_quad
);
    import rycc_pkg::*;

    t_pair       mem [PAIR_DEPTH];
    t_pair       r_rd_data;
    t_pair       wr_data;
    t_pix_val    r_left;
    t_quad       r_quad, n_quad;
    logic        r_quad_valid;
    logic        rd_en, wr_en, left_en, quad_hit;
    logic [24:0] cb_total, cr_total;

    assign rd_en    = i_en && i_b_valid && i_b_pos.col_odd && i_b_pos.row_odd;
    assign wr_en    = i_en && i_c_valid && i_c_pos.col_odd && !i_c_pos.row_odd;
    assign left_en  = i_en && i_c_valid && !i_c_pos.col_odd;
    assign quad_hit = i_c_valid && i_c_pos.col_odd && i_c_pos.row_odd;

    always_comb begin
        wr_data.luma_left  = r_left.luma;
        wr_data.luma_right = i_c_val.luma;
        wr_data.cb_sum     = {1'b0, r_left.cb14} + {1'b0, i_c_val.cb14};
        wr_data.cr_sum     = {1'b0, r_left.cr14} + {1'b0, i_c_val.cr14};
    end

    always_comb begin
        cb_total = {2'b0, r_rd_data.cb_sum} + {3'b0, r_left.cb14}
                 + {3'b0, i_c_val.cb14} + AVG_ROUND;
        cr_total = {2'b0, r_rd_data.cr_sum} + {3'b0, r_left.cr14}
                 + {3'b0, i_c_val.cr14} + AVG_ROUND;
        n_quad.luma_top_left     = r_rd_data.luma_left;
        n_quad.luma_top_right    = r_rd_data.luma_right;
        n_quad.luma_bottom_left  = r_left.luma;
        n_quad.luma_bottom_right = i_c_val.luma;
        n_quad.blue_chroma_avg   = cb_total[23:16];
        n_quad.red_chroma_avg    = cr_total[23:16];
    end

    // line store: read one stage ahead so the entry is in hand at stage C
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_c_pos.idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[i_b_pos.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (left_en) begin
            r_left <= i_c_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad_valid <= 1'b0;
        end else if (i_en) begin
            r_quad_valid <= quad_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && quad_hit) begin
            r_quad <= n_quad;
        end
    end

    assign o_quad.valid   = r_quad_valid;
    assign o_quad.payload = r_quad;

    // a bottom-row read and a top-row write never hit the same entry together
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en && wr_en |-> i_b_pos.idx != i_c_pos.idx)
        else $error("line store read and write collide");

    // reads and writes belong to different rows, so a read and a write in one edge never share a row parity
    a_rw_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en && i_b_pos.row_odd == i_c_pos.row_odd))
        else $error("read and write from the same row parity");

endmodule

// File: sv/rgb_to_ycbcr420_converter.sv
// Top level of the RGB to YCbCr 4:2:0 converter: handshake, raster counters, config.
// Depends on rycc_pkg, rycc_if, rycc_color_calc and rycc_pair_store.
//
// Usage
//   i_pix  : one RGB pixel item per handshake, raster order, 8 bits per channel.
//   o_quad : one 4:2:0 quad item per 2x2 block, issued on the bottom-right pixel:
//            four lumas (BT.601 studio range) plus rounded mean Cb and Cr.
//   config : i_cfg_we / i_cfg_idx / i_cfg_data write line_width or frame_height;
//            low bit ignored, value clamped to 2..4096. Write only while idle.
// Throughput: one pixel item per clock unless the output stalls (see Stall). Every stage
//   of the pipe is a register stage; the line store has one write and one read port, a
//   top-row pair is written once and read once, so no item ever waits on the memory.
// Path: the capture register loads on the edge that accepts the bottom-right pixel,
//   then the products, the sums and the output register load in turn on enabled
//   edges, and the quad appears on o_quad from the output register.
// Reset: counters go to the top-left of a frame, registers to 640 x 480, the
//   output register empties. The line store is not cleared: a bottom row is
//   only meaningful after its top row has been fed in.
// Stall: while a quad sits in the output register and is not taken, the whole
//   pipe holds and i_pix.ready is low; otherwise ready stays high.
module rgb_to_ycbcr420_converter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rycc_pix_if.sink                 i_pix,
    rycc_quad_if.source              o_quad,
    input  logic                     i_cfg_we,
    input  rycc_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [rycc_pkg::CFG_W-1:0] i_cfg_data
);
    import rycc_pkg::*;

    logic [CFG_W-1:0] r_line_width, r_frame_height;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [CNT_W-1:0] col_inc, row_inc;
    logic             col_wrap;
    logic             en, accept;
    t_pos             in_pos;
    logic             b_valid, c_valid;
    t_pos             b_pos, c_pos;
    t_pix_val         c_val;

    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] cap);
        logic [CFG_W-1:0] e;
        e = {v[CFG_W-1:1], 1'b0};
        if (e < CFG_W'(2)) begin
            e = CFG_W'(2);
        end
        if (e > cap) begin
            e = cap;
        end
        return e;
    endfunction

    // pipe advances unless a quad is stuck in the output register
    assign en          = !o_quad.valid || o_quad.ready;
    assign i_pix.ready = en;
    assign accept      = i_pix.valid && en;

    assign w_eff = eff_size(r_line_width, CFG_W'(MAX_LINE_WIDTH));
    assign h_eff = eff_size(r_frame_height, CFG_W'(MAX_FRAME_HEIGHT));

    assign in_pos.col_odd = r_col[0];
    assign in_pos.row_odd = r_row[0];
    assign in_pos.idx     = r_col[PAIR_IDX_W:1];

    // next raster position; a counter past a shrunk size wraps on its next step
    always_comb begin
        col_inc  = r_col + CNT_W'(1);
        row_inc  = r_row + CNT_W'(1);
        col_wrap = ({1'b0, col_inc} >= w_eff) || (col_inc == '0);
        n_col    = r_col;
        n_row    = r_row;
        if (accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = ({1'b0, row_inc} >= h_eff) ? '0 : row_inc;
            end else begin
                n_col = col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    rycc_color_calc u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_pix.valid),
        .i_pix     (i_pix.payload),
        .i_pos     (in_pos),
        .o_b_valid (b_valid),
        .o_b_pos   (b_pos),
        .o_c_valid (c_valid),
        .o_c_pos   (c_pos),
        .o_c_val   (c_val)
    );

    rycc_pair_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_b_valid (b_valid),
        .i_b_pos   (b_pos),
        .i_c_valid (c_valid),
        .i_c_pos   (c_pos),
        .i_c_val   (c_val),
        .o_quad    (o_quad)
    );

    // a waiting quad must hold back the input side
    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quad.valid && !o_quad.ready |-> !i_pix.ready)
        else $error("input accepted while output stalled");

    // each accepted pixel steps the column by one or wraps it to zero
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_col == $past(r_col) + CNT_W'(1)) || (r_col == '0))
        else $error("column counter skipped");

endmodule

// File: sim/ycbcr_quad_checker.sv
// Scoreboard for the RGB to YCbCr 4:2:0 converter: watches both channels and the
// register port, predicts every quad item and compares it field by field.
// Depends on rycc_pkg and rycc_if.
module ycbcr_quad_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rycc_pix_if                        i_pix_mon,
    rycc_quad_if                       i_quad_mon,
    input  logic                       i_cfg_we,
    input  rycc_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [rycc_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_mismatches,
    output int                         o_quads_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import rycc_pkg::*;

    // BT.601 chroma rows, scaled by 2^16
    localparam int CB_KR = -9714;
    localparam int CB_KG = -19070;
    localparam int CB_KB = 28784;
    localparam int CR_KR = 28784;
    localparam int CR_KG = -24103;
    localparam int CR_KB = -4681;

    typedef struct {
        logic [7:0]  luma_l;
        logic [7:0]  luma_r;
        logic [22:0] cb_sum;
        logic [22:0] cr_sum;
    } t_top_pair;

    t_top_pair        top_pairs [PAIR_DEPTH];
    logic [CNT_W-1:0] col_pos;
    logic [CNT_W-1:0] row_pos;
    logic [7:0]       held_luma;
    logic [21:0]      held_cb;
    logic [21:0]      held_cr;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_quad            owed_quads [$];

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] raw, int unsigned cap);
        int unsigned v;
        v = {raw[CFG_W-1:1], 1'b0};
        if (v < 2) v = 2;
        if (v > cap) v = cap;
        return v;
    endfunction

    function automatic logic [7:0] pixel_luma(t_pixel px);
        int unsigned acc;
        acc = 16829 * int'(px.red) + 33039 * int'(px.green) + 6416 * int'(px.blue)
            + (16 << 16) + (1 << 15);
        return acc[23:16];
    endfunction

    // 14 fraction bits; the 128 offset keeps the sum positive
    function automatic logic [21:0] pixel_chroma14(int kr, int kg, int kb, t_pixel px);
        int acc;
        acc = (128 << 16) + kr * int'(px.red) + kg * int'(px.green) + kb * int'(px.blue) + 2;
        return acc[23:2];
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_mismatches++;
        end
    endtask

    task automatic predict_pixel(t_pixel px);
        int unsigned           w;
        int unsigned           h;
        int unsigned           cbs;
        int unsigned           crs;
        logic [7:0]            y;
        logic [21:0]           cb;
        logic [21:0]           cr;
        logic [PAIR_IDX_W-1:0] slot;
        t_quad                 q;
        w    = clamp_size(width_reg, MAX_LINE_WIDTH);
        h    = clamp_size(height_reg, MAX_FRAME_HEIGHT);
        y    = pixel_luma(px);
        cb   = pixel_chroma14(CB_KR, CB_KG, CB_KB, px);
        cr   = pixel_chroma14(CR_KR, CR_KG, CR_KB, px);
        slot = col_pos[CNT_W-1:1];

        if (!col_pos[0]) begin
            held_luma = y;
            held_cb   = cb;
            held_cr   = cr;
        end else if (!row_pos[0]) begin
            top_pairs[slot].luma_l = held_luma;
            top_pairs[slot].luma_r = y;
            top_pairs[slot].cb_sum = 23'(held_cb) + 23'(cb);
            top_pairs[slot].cr_sum = 23'(held_cr) + 23'(cr);
        end else begin
            cbs = top_pairs[slot].cb_sum + held_cb + cb + (1 << 15);
            crs = top_pairs[slot].cr_sum + held_cr + cr + (1 << 15);
            q.luma_top_left     = top_pairs[slot].luma_l;
            q.luma_top_right    = top_pairs[slot].luma_r;
            q.luma_bottom_left  = held_luma;
            q.luma_bottom_right = y;
            q.blue_chroma_avg   = cbs[23:16];
            q.red_chroma_avg    = crs[23:16];
            owed_quads.push_back(q);
        end

        // counters keep running across size changes; past the end they wrap
        col_pos = col_pos + 1'b1;
        if (col_pos == '0 || col_pos >= w) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            if (row_pos >= h) row_pos = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_quad got;
        t_quad want;
        if (!i_rst_n) begin
            col_pos      = '0;
            row_pos      = '0;
            held_luma    = '0;
            held_cb      = '0;
            held_cr      = '0;
            width_reg    = 13'd640;
            height_reg   = 13'd480;
            o_mismatches = 0;
            owed_quads.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_WIDTH:   width_reg  = i_cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_quad_mon.valid && i_quad_mon.ready) begin
                got = i_quad_mon.payload;
                if (owed_quads.size() == 0) begin
                    $error("quad item arrived with no prediction waiting");
                    o_mismatches++;
                end else begin
                    want = owed_quads.pop_front();
                    check_field("luma_top_left", want.luma_top_left, got.luma_top_left);
                    check_field("luma_top_right", want.luma_top_right, got.luma_top_right);
                    check_field("luma_bottom_left", want.luma_bottom_left,
                                got.luma_bottom_left);
                    check_field("luma_bottom_right", want.luma_bottom_right,
                                got.luma_bottom_right);
                    check_field("blue_chroma_avg", want.blue_chroma_avg, got.blue_chroma_avg);
                    check_field("red_chroma_avg", want.red_chroma_avg, got.red_chroma_avg);
                end
            end
            if (i_pix_mon.valid && i_pix_mon.ready) predict_pixel(i_pix_mon.payload);
        end
        o_quads_owed = owed_quads.size();
    end

endmodule

// File: sim/testbench.sv
// Top of the converter testbench: clock, reset, pixel stimulus, quad back-pressure,
// register writes, watchdog and verdict. Checking lives in ycbcr_quad_checker.
// Depends on rycc_pkg, rycc_if, ycbcr_quad_checker and the converter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rycc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    // output register sits behind the capture, product and sum registers; allow some margin
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 440;
    localparam int PRESSURE_PHASE = 4;
    // top-row pairs written up front; covers every column the random bursts reach
    localparam int PREFILL_ITEMS  = 160;
    localparam int NARROW_ITEMS   = 64;

    typedef enum int {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } t_idle_mode;

    // Primary and secondary colours and the two extremes, laid out as a 4x2 frame:
    // row 0 holds black, white, red, green; row 1 blue, yellow, cyan, magenta.
    localparam t_pixel CORNER_PIXELS [8] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               mismatches;
    int               quads_owed;
    int               src_idle_pct;
    int               snk_stall_pct;
    int               holds_asked  = 0;
    int               holds_served = 0;
    int               quiet_cycles = 0;

    rycc_pix_if  pix_ch ();
    rycc_quad_if quad_ch ();

    rgb_to_ycbcr420_converter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_ch),
        .o_quad     (quad_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ycbcr_quad_checker quad_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix_mon    (pix_ch),
        .i_quad_mon   (quad_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_quads_owed (quads_owed)
    );

    always #CLK_HALF clk = ~clk;

    // Quad receiver. Normally ready is drawn each cycle from the stall rate; when
    // a hold-off is asked for, ready stays low for a long counted stretch so that
    // the output register fills and the converter has to stall its pixel input.
    initial begin
        quad_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != holds_asked) begin
                quad_ch.ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge clk);
                holds_served++;
            end
            quad_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog: any long spell without a handshake on either channel is a hang
    always @(posedge clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (quad_ch.valid && quad_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apply_idling(t_idle_mode mode);
        case (mode)
            IDLE_SOURCE: begin
                src_idle_pct  = 83;
                snk_stall_pct = 0;
            end
            IDLE_SINK: begin
                src_idle_pct  = 0;
                snk_stall_pct = 83;
            end
            IDLE_BOTH: begin
                src_idle_pct  = 37;
                snk_stall_pct = 37;
            end
            default: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
        endcase
    endtask

    // Entered and left on a falling edge. Both registers are written on
    // back-to-back edges so the write enable is raised and lowered only once.
    task automatic set_frame(logic [CFG_W-1:0] width, logic [CFG_W-1:0] height);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LINE_WIDTH;
        cfg_data <= width;
        @(negedge clk);
        cfg_idx  <= CFG_FRAME_HEIGHT;
        cfg_data <= height;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Offer one pixel item, with random idle cycles ahead of it, and hold it
    // until the converter takes it. valid stays high on return so that
    // back-to-back items need no extra edge.
    task automatic push_pixel(t_pixel px);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid   <= 1'b1;
        pix_ch.payload <= px;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // End a burst and let the converter go quiet: all quads delivered, then a
    // DRAIN_CYCLES wait for pixels still in the pipe that produce no quad.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (quads_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel px;
        if ($urandom_range(7) == 0) begin
            // saturated channels hit the edges of the luma and chroma ranges
            px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
            px = 24'($urandom);
        end
        return px;
    endfunction

    initial begin
        int         sent;
        int         phase;
        int         burst;
        logic       was_large;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_LINE_WIDTH;
        cfg_data       = '0;
        pix_ch.valid   = 1'b0;
        pix_ch.payload = '0;
        apply_idling(IDLE_NONE);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Smallest useful frame, 4x2, written with odd values to check that
        // the low bit is dropped.
        set_frame(13'd5, 13'd3);
        foreach (CORNER_PIXELS[k]) push_pixel(CORNER_PIXELS[k]);
        settle();

        // Size change in the middle of a top row: the column counter is already
        // past the new width, so it wraps straight into the bottom row, whose
        // pairs were written before the change.
        set_frame(13'd8, 13'd2);
        repeat (6) push_pixel(random_pixel());
        settle();
        set_frame(13'd4, 13'd2);
        repeat (5) push_pixel(random_pixel());
        settle();

        // Widest line (height 0 clamps to 2). Part of a top row only: it fills
        // the leading line store entries, which covers every column that a
        // bottom row reaches from here on.
        set_frame(13'd4096, 13'd0);
        repeat (PREFILL_ITEMS) push_pixel(random_pixel());
        settle();

        // Narrowest line and tallest frame, both from out-of-range values
        set_frame(13'd1, 13'd8191);
        repeat (NARROW_ITEMS) push_pixel(random_pixel());
        settle();

        // Random bursts. Bursts are not aligned to frame boundaries, so a new
        // size can land mid-frame; idling rotates through the four modes. A wide
        // line never follows another, which keeps the column inside the
        // entries written above; the hold-off burst uses a very short line so
        // that quads are sure to pile up behind the stalled receiver.
        sent      = 0;
        phase     = 0;
        was_large = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            apply_idling(t_idle_mode'(phase % 4));
            if (phase != PRESSURE_PHASE && !was_large && $urandom_range(5) == 0) begin
                width     = CFG_W'($urandom_range(41, 8191));
                height    = CFG_W'($urandom_range(13, 8191));
                was_large = 1'b1;
            end else begin
                width     = CFG_W'($urandom_range(0, (phase == PRESSURE_PHASE) ? 8 : 40));
                height    = CFG_W'($urandom_range(0, 12));
                was_large = 1'b0;
            end
            set_frame(width, height);
            // one burst runs against a long receiver hold-off
            if (phase == PRESSURE_PHASE) holds_asked++;
            burst = $urandom_range(40, 90);
            repeat (burst) push_pixel(random_pixel());
            sent += burst;
            phase++;
            settle();
        end

        apply_idling(IDLE_NONE);
        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
